>>> rtl/token_aware_substring_search_assert.svh
// Assertion macros shared by the checker of the substring search block.
// Depends on nothing; included by the checker file only.
`ifndef TOKEN_AWARE_SUBSTRING_SEARCH_ASSERT_SVH
`define TOKEN_AWARE_SUBSTRING_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TASS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TASS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> rtl/tass_pkg.sv
// Shared types, constants and byte helpers of the substring search block.
// No dependencies; used by every other file of the block but the byte interface and the assertion header.
package tass_pkg;

	// Result field width and pattern storage
	localparam int FIELD_W     = 48;
	localparam int PAT_SLOTS   = 32;
	localparam int PAT_WORDS   = 4;
	localparam int LEN_W       = 6;
	localparam int SLOT_IDX_W  = 5;
	localparam int QUEUE_DEPTH = 4;

	// Register port
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	localparam logic [2:0] REG_PAT_0_7     = 3'd0;
	localparam logic [2:0] REG_PAT_8_15    = 3'd1;
	localparam logic [2:0] REG_PAT_16_23   = 3'd2;
	localparam logic [2:0] REG_PAT_24_31   = 3'd3;
	localparam logic [2:0] REG_PAT_LEN     = 3'd4;
	localparam logic [2:0] REG_IGNORE_CASE = 3'd5;
	localparam logic [2:0] REG_WHOLE_TOKEN = 3'd6;

	// Character codes
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CHAR_USCORE  = 8'h5F;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CASE_DELTA   = 8'h20;

	// Match setup derived from the registers: pattern right-aligned to the
	// newest byte, already case folded, with a mask of the slots in use
	typedef struct packed {
		logic [PAT_SLOTS-1:0][7:0] apat;
		logic [PAT_SLOTS-1:0]      care;
		logic [SLOT_IDX_W-1:0]     len_m1;
		logic [7:0]                pat0;
		logic                      ignore_case;
		logic                      whole_token;
	} tass_cfg_t;

	// One queue entry: a result, or a marker that only closes a file
	typedef struct packed {
		logic               mark;
		logic               run_end;
		logic               file_end;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] line;
	} tass_rec_t;

	// Up to two entries written per processed byte
	typedef struct packed {
		logic [1:0] count;
		tass_rec_t  rec0;
		tass_rec_t  rec1;
	} tass_push_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c, input logic ic);
		logic upper;
		upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
		return (ic && upper) ? c + CASE_DELTA : c;
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		logic digit, upper, lower;
		digit = (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
		upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
		lower = (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
		return digit || upper || lower || (c == CHAR_USCORE);
	endfunction

endpackage

>>> rtl/tass_byte_if.sv
// Input byte channel of the substring search block: valid/ready plus payload.
// No dependencies.
interface tass_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source(output valid, data_byte, end_of_file, input ready);
	modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

>>> rtl/tass_match_if.sv
// Result channel of the substring search block: valid/ready plus payload.
// Depends on tass_pkg for the field width.
interface tass_match_if;
	logic                         valid;
	logic                         ready;
	logic [tass_pkg::FIELD_W-1:0] match_offset;
	logic [tass_pkg::FIELD_W-1:0] line_number;
	logic [tass_pkg::FIELD_W-1:0] match_ordinal;
	logic                         run_end;

	modport source(output valid, match_offset, line_number, match_ordinal, run_end,
		input ready);
	modport sink(input valid, match_offset, line_number, match_ordinal, run_end,
		output ready);
endinterface

>>> rtl/tass_cfg.sv
// APB register file of the substring search block, plus the registered
// match setup (aligned, folded pattern) derived from it. Depends on tass_pkg.
module tass_cfg #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tass_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [tass_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [tass_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	output tass_pkg::tass_cfg_t               cfg
);

	localparam int LW = tass_pkg::LEN_W;
	localparam int SW = tass_pkg::SLOT_IDX_W;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

	logic [tass_pkg::PAT_WORDS-1:0][tass_pkg::CFG_DATA_W-1:0] pat_q;
	logic [LW-1:0] len_q;
	logic          ic_q;
	logic          wt_q;
	tass_pkg::tass_cfg_t cfg_q;
	tass_pkg::tass_cfg_t cfg_next;

	logic       wr_en;
	logic [2:0] reg_idx;
	logic [tass_pkg::PAT_SLOTS-1:0][7:0] pat_b;
	logic [LW-1:0] len_eff;
	logic [SW-1:0] len_m1;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[5:3];
	assign pat_b   = pat_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= LW'(1);
			ic_q  <= 1'b0;
			wt_q  <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				tass_pkg::REG_PAT_0_7:     pat_q[0] <= pwdata;
				tass_pkg::REG_PAT_8_15:    pat_q[1] <= pwdata;
				tass_pkg::REG_PAT_16_23:   pat_q[2] <= pwdata;
				tass_pkg::REG_PAT_24_31:   pat_q[3] <= pwdata;
				tass_pkg::REG_PAT_LEN:     len_q <= pwdata[LW-1:0];
				tass_pkg::REG_IGNORE_CASE: ic_q <= pwdata[0];
				tass_pkg::REG_WHOLE_TOKEN: wt_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		prdata = '0;
		case (reg_idx)
			tass_pkg::REG_PAT_0_7:     prdata = pat_q[0];
			tass_pkg::REG_PAT_8_15:    prdata = pat_q[1];
			tass_pkg::REG_PAT_16_23:   prdata = pat_q[2];
			tass_pkg::REG_PAT_24_31:   prdata = pat_q[3];
			tass_pkg::REG_PAT_LEN:     prdata = tass_pkg::CFG_DATA_W'(len_q);
			tass_pkg::REG_IGNORE_CASE: prdata = tass_pkg::CFG_DATA_W'(ic_q);
			tass_pkg::REG_WHOLE_TOKEN: prdata = tass_pkg::CFG_DATA_W'(wt_q);
			default:                   prdata = '0;
		endcase
	end

	// Length clamped to 1..MAX_PATTERN
	assign len_eff = (len_q == '0) ? LW'(1) : ((len_q > MAX_LEN) ? MAX_LEN : len_q);
	assign len_m1  = SW'(len_eff - LW'(1));

	// Slot j faces the byte j places back from the newest one
	always_comb begin
		cfg_next = '0;
		for (int j = 0; j < tass_pkg::PAT_SLOTS; j++) begin
			if (SW'(j) <= len_m1) begin
				cfg_next.apat[j] = tass_pkg::fold_case(pat_b[len_m1 - SW'(j)], ic_q);
				cfg_next.care[j] = 1'b1;
			end
		end
		cfg_next.len_m1      = len_m1;
		cfg_next.pat0        = tass_pkg::fold_case(pat_b[0], ic_q);
		cfg_next.ignore_case = ic_q;
		cfg_next.whole_token = wt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			cfg_q <= cfg_next;
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/tass_fifo.sv
// Short result queue between matcher and output stage: two writes, one read
// per cycle, flop storage. Depends on tass_pkg.
module tass_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tass_pkg::tass_push_t push,
	output logic                 room2,
	output logic                 head_valid,
	output tass_pkg::tass_rec_t  head,
	input  logic                 pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tass_pkg::tass_rec_t mem_q [DEPTH];
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] wp_1;
	logic [PW-1:0] wp_2;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
		return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
	endfunction

	assign wp_1       = ptr_inc(wp_q);
	assign wp_2       = ptr_inc(wp_1);
	assign head       = mem_q[rp_q];
	assign head_valid = (cnt_q != '0);
	assign room2      = (cnt_q <= CW'(DEPTH - 2));

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wp_q] <= push.rec0;
		end
		if (push.count == 2'd2) begin
			mem_q[wp_1] <= push.rec1;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.count == 2'd2) begin
				wp_q <= wp_2;
			end else if (push.count == 2'd1) begin
				wp_q <= wp_1;
			end
			if (pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			cnt_q <= cnt_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

>>> rtl/tass_front.sv
// Front of the substring search block: takes bytes, keeps the byte window,
// compares against the pattern, counts lines and writes results to the queue.
// Depends on tass_pkg and tass_byte_if.
module tass_front #(
	parameter int MAX_PATTERN = 32,
	parameter int OFFSET_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tass_byte_if.sink            byte_stream,
	input  tass_pkg::tass_cfg_t  cfg,
	input  logic                 room2,
	output tass_pkg::tass_push_t push
);

	localparam int FW = tass_pkg::FIELD_W;
	localparam logic [OFFSET_BITS-1:0] POS_MAX   = '1;
	localparam logic [FW-1:0]          COUNT_MAX = '1;
	localparam int SW = tass_pkg::SLOT_IDX_W;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       go;

	// Search state
	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] blk_q;
	logic [FW-1:0]          cr_q;
	logic [FW-1:0]          lf_q;
	logic                   pend_q;
	logic [OFFSET_BITS-1:0] pstart_q;
	logic [FW-1:0]          pline_q;

	logic [MAX_PATTERN:0][7:0] cur;
	logic [7:0] cur_last;
	logic [7:0] prev_byte;
	logic       hit;
	logic [OFFSET_BITS-1:0] lm1;
	logic [OFFSET_BITS-1:0] start_pos;
	logic [OFFSET_BITS-1:0] pos_next;
	logic       window_open;
	logic       past_len;
	logic [FW-1:0] cur_line;
	logic       emit0;
	logic       keep;
	logic       hit_ok;
	logic       new_hit;
	logic       emit1;
	logic       count_line;
	logic       cr_inc;
	logic       lf_inc;
	tass_pkg::tass_rec_t rec_pend;
	tass_pkg::tass_rec_t rec_now;
	tass_pkg::tass_rec_t rec_mark;

	// Handshake: a byte moves on when two queue slots are free
	assign go                = valid_s1 && room2;
	assign byte_stream.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.data_byte;
			eof_s1  <= byte_stream.end_of_file;
		end
	end

	// Window view with the current byte at place 0
	always_comb begin
		cur[0] = byte_s1;
		for (int k = 1; k <= MAX_PATTERN; k++) begin
			cur[k] = win_q[k-1];
		end
	end

	// Parallel compare against the aligned pattern
	always_comb begin
		hit = 1'b1;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (cfg.care[j] &&
				(tass_pkg::fold_case(cur[j], cfg.ignore_case) != cfg.apat[j])) begin
				hit = 1'b0;
			end
		end
	end

	// Oldest byte of the candidate and the byte before it
	always_comb begin
		cur_last  = '0;
		prev_byte = '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (SW'(j) == cfg.len_m1) begin
				cur_last  = cur[j];
				prev_byte = cur[j+1];
			end
		end
	end

	// Position checks
	assign lm1         = OFFSET_BITS'(cfg.len_m1);
	assign start_pos   = pos_q - lm1;
	assign window_open = (pos_q >= lm1) && (start_pos >= blk_q);
	assign past_len    = (pos_q > lm1);
	assign pos_next    = (pos_q == POS_MAX) ? pos_q : pos_q + OFFSET_BITS'(1);
	assign cur_line    = (cr_q > lf_q) ? cr_q : lf_q;

	// Occurrence decisions
	assign emit0   = pend_q && !(cfg.whole_token && tass_pkg::is_token(byte_s1));
	assign keep    = !(cfg.whole_token && past_len && tass_pkg::is_token(prev_byte));
	assign hit_ok  = window_open && hit;
	assign new_hit = hit_ok && keep;
	assign emit1   = new_hit && eof_s1;

	// Line counting of the settled byte
	assign count_line = window_open && !hit &&
		(tass_pkg::fold_case(cur_last, cfg.ignore_case) != cfg.pat0);
	assign cr_inc = count_line && (cur_last == tass_pkg::CHAR_CR);
	assign lf_inc = count_line && (cur_last == tass_pkg::CHAR_LF);

	// Queue entries
	always_comb begin
		rec_pend          = '0;
		rec_pend.run_end  = !emit1;
		rec_pend.file_end = eof_s1 && !emit1;
		rec_pend.start    = FW'(pstart_q);
		rec_pend.line     = pline_q;

		rec_now          = '0;
		rec_now.run_end  = 1'b1;
		rec_now.file_end = eof_s1;
		rec_now.start    = FW'(start_pos);
		rec_now.line     = cur_line;

		rec_mark          = '0;
		rec_mark.mark     = 1'b1;
		rec_mark.file_end = 1'b1;
	end

	always_comb begin
		push = '0;
		if (go) begin
			if (emit0) begin
				push.rec0 = rec_pend;
				if (emit1) begin
					push.rec1  = rec_now;
					push.count = 2'd2;
				end else begin
					push.count = 2'd1;
				end
			end else if (emit1) begin
				push.rec0  = rec_now;
				push.count = 2'd1;
			end else if (eof_s1) begin
				push.rec0  = rec_mark;
				push.count = 2'd1;
			end
		end
	end

	// Window shift
	always_ff @(posedge clk) begin
		if (go) begin
			win_q[0] <= byte_s1;
			for (int k = 1; k < MAX_PATTERN; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// Pending occurrence payload
	always_ff @(posedge clk) begin
		if (go && new_hit && !eof_s1) begin
			pstart_q <= start_pos;
			pline_q  <= cur_line;
		end
	end

	// Counters and flags; all return to reset values after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			blk_q  <= '0;
			cr_q   <= FW'(1);
			lf_q   <= FW'(1);
			pend_q <= 1'b0;
		end else if (go) begin
			if (eof_s1) begin
				pos_q  <= '0;
				blk_q  <= '0;
				cr_q   <= FW'(1);
				lf_q   <= FW'(1);
				pend_q <= 1'b0;
			end else begin
				pos_q  <= pos_next;
				pend_q <= new_hit;
				if (hit_ok) begin
					blk_q <= pos_next;
				end
				if (cr_inc && (cr_q != COUNT_MAX)) begin
					cr_q <= cr_q + FW'(1);
				end
				if (lf_inc && (lf_q != COUNT_MAX)) begin
					lf_q <= lf_q + FW'(1);
				end
			end
		end
	end

endmodule

>>> rtl/tass_back.sv
// Back of the substring search block: drains the result queue, numbers the
// occurrences of each file and holds the output register. Depends on tass_pkg
// and tass_match_if.
module tass_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tass_pkg::tass_rec_t head,
	input  logic                head_valid,
	output logic                pop,
	tass_match_if.source        results
);

	localparam int FW = tass_pkg::FIELD_W;
	localparam logic [FW-1:0] COUNT_MAX = '1;

	logic          out_valid_q;
	logic [FW-1:0] offset_q;
	logic [FW-1:0] line_q;
	logic [FW-1:0] ordinal_q;
	logic          run_end_q;
	logic [FW-1:0] ord_q;
	logic [FW-1:0] ord_inc;
	logic          load;

	// Markers are consumed at once; results wait for a free output register
	assign load    = head_valid && !head.mark && (!out_valid_q || results.ready);
	assign pop     = head_valid && (head.mark || !out_valid_q || results.ready);
	assign ord_inc = (ord_q == COUNT_MAX) ? ord_q : ord_q + FW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ord_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.mark || head.file_end) begin
					ord_q <= '0;
				end else begin
					ord_q <= ord_inc;
				end
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			offset_q  <= head.start;
			line_q    <= head.line;
			ordinal_q <= ord_inc;
			run_end_q <= head.run_end;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.match_offset  = offset_q;
	assign results.line_number   = line_q;
	assign results.match_ordinal = ordinal_q;
	assign results.run_end       = run_end_q;

endmodule

>>> rtl/token_aware_substring_search.sv
// Path: the byte that releases a result, i.e. the byte after the occurrence or the
// last byte, enters the input register; its result then passes the result queue and the output register.
// Throughput: one byte per cycle while the result queue can take two entries;
// two results of a byte that closes a file are absorbed by the 4-entry result queue.
// Reset: asynchronous, clears counters, flags and queue at once; pattern
// registers read zero and length one; no clearing pass.
module token_aware_substring_search #(
	parameter int MAX_PATTERN = 32,
	parameter int OFFSET_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tass_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [tass_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [tass_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	tass_byte_if.sink                       byte_stream,
	tass_match_if.source                    results
);

	tass_pkg::tass_cfg_t  cfg;
	tass_pkg::tass_push_t push;
	tass_pkg::tass_rec_t  head;
	logic                 room2;
	logic                 head_valid;
	logic                 pop;

	// Registers and derived match setup
	tass_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Byte intake and matching
	tass_front #(
		.MAX_PATTERN(MAX_PATTERN),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.cfg        (cfg),
		.room2      (room2),
		.push       (push)
	);

	// Result queue
	tass_fifo #(
		.DEPTH(tass_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	// Numbering and output register
	tass_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.results   (results)
	);

endmodule

>>> rtl/tass_checker.sv
// Port-level checks of the substring search block, bound to its top level.
// Depends on tass_pkg and token_aware_substring_search_assert.svh.
`include "token_aware_substring_search_assert.svh"

module tass_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [tass_pkg::FIELD_W-1:0] match_offset,
	input logic [tass_pkg::FIELD_W-1:0] line_number,
	input logic [tass_pkg::FIELD_W-1:0] match_ordinal,
	input logic                         run_end
);

	// A stalled result holds
	`TASS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(match_offset) && $stable(line_number) && $stable(match_ordinal) && $stable(run_end), "stalled result changed")

	// The second result of a byte follows at once with the next ordinal
	`TASS_ASSERT_NEXT(a_pair_follows, clk, arst_n, out_valid && out_ready && !run_end, out_valid && ((match_ordinal == $past(match_ordinal) + 1'b1) || ($past(match_ordinal) == '1)), "second result missing or misnumbered")

	// Ordinal and line number count from one
	`TASS_ASSERT_NOW(a_counts_nonzero, clk, arst_n, out_valid, (match_ordinal != '0) && (line_number != '0), "zero ordinal or line number")

endmodule

bind token_aware_substring_search tass_checker u_tass_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.match_offset (results.match_offset),
	.line_number  (results.line_number),
	.match_ordinal(results.match_ordinal),
	.run_end      (results.run_end)
);
